// ----- rtl/xild_pkg.sv -----
package xild_pkg;

    // REX prefix window and its W bit
    localparam logic [7:0] REX_LO   = 8'h40;
    localparam logic [7:0] REX_HI   = 8'h4F;
    localparam int unsigned REX_W_BIT = 3;

    // ModRM field codes
    localparam logic [1:0] MOD_IND  = 2'd0;
    localparam logic [1:0] MOD_D8   = 2'd1;
    localparam logic [1:0] MOD_D32  = 2'd2;
    localparam logic [1:0] MOD_REG  = 2'd3;
    localparam logic [2:0] RM_SIB   = 3'd4;
    localparam logic [2:0] RM_RIP   = 3'd5;

    localparam int unsigned LEN_W   = 4;

    // Opcode class: fixed length, or base length plus ModRM tail
    typedef struct packed {
        logic             use_modrm;
        logic [LEN_W-1:0] base;
        logic [7:0]       modrm;
    } t_class;

    // Bytes added by SIB and displacement for a given ModRM byte
    function automatic logic [LEN_W-1:0] modrm_tail(input logic [7:0] m);
        logic [1:0]       md;
        logic [2:0]       rm;
        logic [LEN_W-1:0] n;
        md = m[7:6];
        rm = m[2:0];
        n  = '0;
        if (md != MOD_REG) begin
            if (rm == RM_SIB) n = n + LEN_W'(1);
            if (md == MOD_IND && rm == RM_RIP) n = n + LEN_W'(4);
            if (md == MOD_D8) n = n + LEN_W'(1);
            if (md == MOD_D32) n = n + LEN_W'(4);
        end
        return n;
    endfunction

endpackage

// ----- rtl/x86_64_instruction_length_decode.sv -----
// channel  dir  tdata fields (low bit up)                                   
// s_axis   in   [7:0] first_byte, [15:8] second_byte, [23:16] third_byte,
//               [31:24] fourth_byte
// m_axis   out  [3:0] length, [7:4] zero
//
// Three register stages: prefix strip, opcode classify, ModRM tail add.
// One transaction per cycle sustained while m_axis is ready; o_m_axis_tvalid
// is the stage 3 valid bit. Each stage advances when the stage after it is
// empty or moving; a stall on m_axis holds all stages without loss or repeat.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
module x86_64_instruction_length_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // first_byte, second_byte, third_byte, fourth_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // length[3:0], zero pad
);

    localparam int unsigned LW = xild_pkg::LEN_W;

    logic ready1, ready2, ready3;

    // stage 1: REX strip
    logic       r1_valid;
    logic       r1_rex, r1_rexw;
    logic [7:0] r1_op, r1_nx, r1_nn;
    logic       n1_rex;
    logic [7:0] b0, b1, b2, b3;

    // stage 2: class
    logic             r2_valid;
    xild_pkg::t_class r2_cls;
    xild_pkg::t_class n2_cls;

    // stage 3: output
    logic          r3_valid;
    logic [LW-1:0] r3_len;
    logic [LW-1:0] n3_len;

    assign ready3 = !r3_valid || i_m_axis_tready;
    assign ready2 = !r2_valid || ready3;
    assign ready1 = !r1_valid || ready2;
    assign o_s_axis_tready = ready1;

    assign b0 = i_s_axis_tdata[7:0];
    assign b1 = i_s_axis_tdata[15:8];
    assign b2 = i_s_axis_tdata[23:16];
    assign b3 = i_s_axis_tdata[31:24];
    assign n1_rex = (b0 >= xild_pkg::REX_LO) && (b0 <= xild_pkg::REX_HI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (ready1) begin
            r1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_s_axis_tvalid) begin
            r1_rex  <= n1_rex;
            r1_rexw <= n1_rex && b0[xild_pkg::REX_W_BIT];
            r1_op   <= n1_rex ? b1 : b0;
            r1_nx   <= n1_rex ? b2 : b1;
            r1_nn   <= n1_rex ? b3 : b2;
        end
    end

    xild_class u_class (
        .i_rex  (r1_rex),
        .i_rexw (r1_rexw),
        .i_op   (r1_op),
        .i_nx   (r1_nx),
        .i_nn   (r1_nn),
        .o_cls  (n2_cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (ready2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r1_valid) begin
            r2_cls <= n2_cls;
        end
    end

    assign n3_len = r2_cls.use_modrm
                  ? r2_cls.base + xild_pkg::modrm_tail(r2_cls.modrm)
                  : r2_cls.base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (ready3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && r2_valid) begin
            r3_len <= n3_len;
        end
    end

    assign o_m_axis_tvalid = r3_valid;
    assign o_m_axis_tdata  = {(8 - LW)'(0), r3_len};

endmodule

// ----- rtl/xild_class.sv -----
module xild_class (
    input  logic              i_rex,
    input  logic              i_rexw,
    input  logic [7:0]        i_op,
    input  logic [7:0]        i_nx,
    input  logic [7:0]        i_nn,
    output xild_pkg::t_class  o_cls
);

    localparam logic [7:0] OP_PUSH_LO = 8'h50;
    localparam logic [7:0] OP_POP_HI  = 8'h5F;
    localparam logic [7:0] OP_GRP1_I8 = 8'h83;
    localparam logic [7:0] OP_GRP1_I32 = 8'h81;
    localparam logic [7:0] OP_MOV_I32 = 8'hC7;
    localparam logic [7:0] OP_MOV_I8  = 8'hC6;
    localparam logic [7:0] OP_TEST_I32 = 8'hF7;
    localparam logic [7:0] OP_TEST_I8 = 8'hF6;
    localparam logic [7:0] OP_MOVR_LO = 8'hB8;
    localparam logic [7:0] OP_MOVR_HI = 8'hBF;
    localparam logic [7:0] OP_MOVB_LO = 8'hB0;
    localparam logic [7:0] OP_MOVB_HI = 8'hB7;
    localparam logic [7:0] OP_NOP     = 8'h90;
    localparam logic [7:0] OP_RET     = 8'hC3;
    localparam logic [7:0] OP_CALL    = 8'hE8;
    localparam logic [7:0] OP_JMP32   = 8'hE9;
    localparam logic [7:0] OP_JCC8_LO = 8'h70;
    localparam logic [7:0] OP_JCC8_HI = 8'h7F;
    localparam logic [7:0] OP_JMP8    = 8'hEB;
    localparam logic [7:0] OP_ESC     = 8'h0F;
    localparam logic [7:0] OP_MOV_MR8 = 8'h88;
    localparam logic [7:0] OP_MOV_MR  = 8'h89;
    localparam logic [7:0] OP_MOV_RM8 = 8'h8A;
    localparam logic [7:0] OP_MOV_RM  = 8'h8B;
    localparam logic [7:0] OP_LEA     = 8'h8D;
    localparam logic [7:0] OP_CMP_RM  = 8'h3B;
    localparam logic [7:0] OP_CMP_RM8 = 8'h3A;
    localparam logic [7:0] OP_SUB_RM  = 8'h2B;
    localparam logic [7:0] OP_SUB_RM8 = 8'h2A;
    localparam logic [7:0] OP_ADD_RM  = 8'h03;
    localparam logic [7:0] OP_ADD_MR  = 8'h01;
    localparam logic [7:0] OP_XOR_RM  = 8'h33;
    localparam logic [7:0] OP_TEST_MR = 8'h85;
    localparam logic [7:0] OP_XOR_MR  = 8'h31;
    localparam logic [7:0] OP_SUB_MR  = 8'h29;
    localparam logic [7:0] OP_CMP_MR  = 8'h39;
    localparam logic [7:0] OP_GRP5    = 8'hFF;
    // second byte after the 0F escape
    localparam logic [7:0] X_MOVZX8   = 8'hB6;
    localparam logic [7:0] X_MOVZX16  = 8'hB7;
    localparam logic [7:0] X_MOVSX8   = 8'hBE;
    localparam logic [7:0] X_MOVSX16  = 8'hBF;
    localparam logic [7:0] X_NOPL     = 8'h1F;
    localparam logic [7:0] X_JCC_LO   = 8'h80;
    localparam logic [7:0] X_JCC_HI   = 8'h8F;
    localparam logic [7:0] X_CMOV_LO  = 8'h40;
    localparam logic [7:0] X_CMOV_HI  = 8'h4F;

    localparam int unsigned LW = xild_pkg::LEN_W;

    logic [LW-1:0] pre;
    logic          reg0;

    assign pre  = LW'(i_rex);
    assign reg0 = (i_nx[5:3] == 3'd0);

    always_comb begin
        o_cls.use_modrm = 1'b0;
        o_cls.base      = '0;
        o_cls.modrm     = i_nx;
        unique case (i_op) inside
            [OP_PUSH_LO:OP_POP_HI]: begin
                o_cls.base = pre + LW'(1);
            end
            OP_GRP1_I8, OP_MOV_I8: begin
                o_cls.use_modrm = 1'b1;
                o_cls.base      = pre + LW'(3);
            end
            OP_GRP1_I32, OP_MOV_I32: begin
                o_cls.use_modrm = 1'b1;
                o_cls.base      = pre + LW'(6);
            end
            OP_MOV_MR8, OP_MOV_MR, OP_MOV_RM8, OP_MOV_RM, OP_LEA, OP_CMP_RM,
            OP_CMP_RM8, OP_SUB_RM, OP_SUB_RM8, OP_ADD_RM, OP_ADD_MR, OP_XOR_RM,
            OP_TEST_MR, OP_XOR_MR, OP_SUB_MR, OP_CMP_MR, OP_GRP5: begin
                o_cls.use_modrm = 1'b1;
                o_cls.base      = pre + LW'(2);
            end
            // only the test form (reg field 0) is in the subset
            OP_TEST_I32: begin
                if (reg0) begin
                    o_cls.use_modrm = 1'b1;
                    o_cls.base      = pre + LW'(6);
                end
            end
            OP_TEST_I8: begin
                if (reg0) begin
                    o_cls.use_modrm = 1'b1;
                    o_cls.base      = pre + LW'(3);
                end
            end
            [OP_MOVR_LO:OP_MOVR_HI]: begin
                o_cls.base = pre + (i_rexw ? LW'(9) : LW'(5));
            end
            [OP_MOVB_LO:OP_MOVB_HI], [OP_JCC8_LO:OP_JCC8_HI], OP_JMP8: begin
                o_cls.base = pre + LW'(2);
            end
            OP_NOP, OP_RET: begin
                o_cls.base = pre + LW'(1);
            end
            OP_CALL, OP_JMP32: begin
                o_cls.base = pre + LW'(5);
            end
            OP_ESC: begin
                o_cls.modrm = i_nn;
                unique case (i_nx) inside
                    X_MOVZX8, X_MOVZX16, X_MOVSX8, X_MOVSX16, X_NOPL,
                    [X_CMOV_LO:X_CMOV_HI]: begin
                        o_cls.use_modrm = 1'b1;
                        o_cls.base      = pre + LW'(3);
                    end
                    [X_JCC_LO:X_JCC_HI]: begin
                        o_cls.base = pre + LW'(6);
                    end
                    default: begin
                        o_cls.base = '0;
                    end
                endcase
            end
            default: begin
                o_cls.base = '0;
            end
        endcase
    end

endmodule
